>>> sv/lcd4_pkg.sv
package lcd4_pkg;

  // Command codes carried in the cmd field of an input transaction.
  typedef enum logic [2:0] {
    CMD_INSTR  = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_INIT   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_PRINT  = 3'd4
  } cmd_e;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_PULSE = 2'd0,
    REG_BYTE_SETTLE  = 2'd1
  } cfg_reg_e;

  // Operation kinds handed from front to back.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_WAKE = 1'b1
  } op_kind_e;

  typedef enum logic {
    FR_IDLE = 1'b0,
    FR_EMIT = 1'b1
  } front_state_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic        row;
    logic [5:0]  column;
    logic [13:0] number;
  } cmd_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        last;
  } pin_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_t;

  typedef struct packed {
    logic [15:0] enable_pulse_us;
    logic [15:0] byte_settle_us;
  } timing_t;

  typedef struct packed {
    op_kind_e    kind;
    logic        rs;
    logic [7:0]  value;
    logic        clear_extra;
    logic        last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_xfer_t;

  // Reset values of the timing registers.
  localparam logic [15:0] ENABLE_PULSE_RST = 16'd100;
  localparam logic [15:0] BYTE_SETTLE_RST  = 16'd1500;

  // Power-up and wake-up timing.
  localparam logic [15:0] POWER_UP_US    = 16'd15000;
  localparam logic [15:0] CLEAR_EXTRA_US = 16'd5000;
  localparam logic [15:0] WAKE1_WAIT_US  = 16'd500;
  localparam logic [15:0] WAKE2_WAIT_US  = 16'd150;
  localparam logic [15:0] WAKE3_WAIT_US  = 16'd1650;
  localparam logic [15:0] WAKE4_WAIT_US  = 16'd1500;
  localparam logic [3:0]  WAKE_NIB       = 4'h3;
  localparam logic [3:0]  FOUR_BIT_NIB   = 4'h2;

  // Instruction bytes.
  localparam logic [7:0] INSTR_FUNC_SET  = 8'h28;
  localparam logic [7:0] INSTR_DISP_ON   = 8'h0C;
  localparam logic [7:0] INSTR_ENTRY     = 8'h06;
  localparam logic [7:0] INSTR_CLEAR     = 8'h01;
  localparam logic [7:0] INSTR_DDRAM     = 8'h80;
  localparam logic [7:0] ROW1_OFFSET     = 8'h40;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam int         DIGIT_PLACE = 1000;
  localparam int         MAX_LEAD    = 16;

  // Last phase indexes of the back end.
  localparam logic [3:0] BYTE_LAST_PHASE = 4'd4;
  localparam logic [3:0] WAKE_LAST_PHASE = 4'd8;

  // Init steps: the wake-up op at step 0, then four bytes.
  localparam logic [2:0] INIT_LAST_STEP  = 3'd4;
  localparam logic [2:0] PRINT_LAST_STEP = 3'd3;

endpackage

>>> sv/lcd4_chan_if.sv
interface lcd4_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/char_lcd_4bit_interface_sequencer_unit.sv
// Four-bit character LCD write sequencer. Each command transaction (instruction
// byte, data byte, initialize, set cursor, print a four-digit number) turns into
// a run of pin-state transactions on the output channel: RS, RW, E, D7..D4 and
// the time in microseconds those levels must be held, with last set on the
// final one. A byte takes five output transactions, initialize takes 29, set
// cursor five and print twenty; codes 5 to 7 are taken and produce nothing.
// The back end emits one pin state per clock through its output register while
// the output channel is ready; that output stage sets the throughput. The front
// end takes a command and then pushes one byte operation per cycle while the
// queue is not full (digits of a print are peeled off one per push) into a queue
// of QUEUE_DEPTH entries, and is ready for the next command as soon as its last
// push is in, so commands overlap with the pin sequence of the one before. The
// two timing registers (index 0 enable pulse, index 1 byte settle) are written
// through the configuration channel, which is always ready; write them only
// while idle.
module char_lcd_4bit_interface_sequencer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcd4_chan_if.sink   in_ch_i,
  lcd4_chan_if.source out_ch_o,
  lcd4_chan_if.sink   cfg_ch_i
);
  import lcd4_pkg::*;

  timing_t timing_q;
  q_xfer_t q_wr;
  q_xfer_t q_rd;
  logic    q_full;
  logic    q_pop;

  // Configuration writes land in the next cycle.
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.enable_pulse_us <= ENABLE_PULSE_RST;
      timing_q.byte_settle_us  <= BYTE_SETTLE_RST;
    end else if (cfg_ch_i.valid) begin
      case (cfg_reg_e'(cfg_ch_i.payload.index))
        REG_ENABLE_PULSE: timing_q.enable_pulse_us <= cfg_ch_i.payload.data;
        REG_BYTE_SETTLE:  timing_q.byte_settle_us  <= cfg_ch_i.payload.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: accept, classify and split commands into byte and wake-up operations.
  lcd4_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .wr_o    (q_wr),
    .full_i  (q_full)
  );

  // Queue: decouple command intake from pin sequencing.
  lcd4_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  // Back: expand each operation into pin phases, hold on output stall.
  lcd4_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .timing_i (timing_q),
    .rd_i     (q_rd),
    .pop_o    (q_pop),
    .out_ch_o (out_ch_o)
  );

endmodule

>>> sv/lcd4_front.sv
module lcd4_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcd4_chan_if.sink        in_ch_i,
  output lcd4_pkg::q_xfer_t wr_o,
  input  logic             full_i
);
  import lcd4_pkg::*;

  front_state_e state_q, state_d;
  cmd_e         cmd_q;
  logic [7:0]   byte_q;
  logic [13:0]  rem_q;
  logic [2:0]   step_q;

  logic         accept;
  logic         push;
  logic         last_push;
  logic [4:0]   digit;
  logic [13:0]  dec;
  logic [13:0]  rem_left;
  logic [13:0]  rem_next;
  logic [7:0]   cursor_byte;
  logic [7:0]   init_byte;
  logic [7:0]   digit_char;

  assign accept = in_ch_i.valid && in_ch_i.ready;
  assign push   = (state_q == FR_EMIT) && !full_i;

  // Leading digit against multiples of the place value, then scale the rest by ten.
  always_comb begin
    digit = '0;
    dec   = '0;
    for (int k = 1; k <= MAX_LEAD; k++) begin
      if (rem_q >= 14'(k * DIGIT_PLACE)) begin
        digit = 5'(k);
        dec   = 14'(k * DIGIT_PLACE);
      end
    end
  end

  assign rem_left = rem_q - dec;
  assign rem_next = (rem_left << 3) + (rem_left << 1);

  assign cursor_byte = INSTR_DDRAM | (in_ch_i.payload.row ? ROW1_OFFSET : 8'h00)
                     | {2'b00, in_ch_i.payload.column};

  always_comb begin
    case (step_q)
      3'd1:    init_byte = INSTR_FUNC_SET;
      3'd2:    init_byte = INSTR_DISP_ON;
      3'd3:    init_byte = INSTR_ENTRY;
      default: init_byte = INSTR_CLEAR;
    endcase
  end

  assign digit_char = ((step_q == 3'd0) && (digit == 5'd0)) ? ASCII_SPACE
                    : ASCII_ZERO + {3'b000, digit};

  always_comb begin
    case (cmd_q)
      CMD_INIT:  last_push = (step_q == INIT_LAST_STEP);
      CMD_PRINT: last_push = (step_q == PRINT_LAST_STEP);
      default:   last_push = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept && (in_ch_i.payload.cmd <= CMD_PRINT)) begin
          state_d = FR_EMIT;
        end
      end
      FR_EMIT: begin
        if (push && last_push) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ch_i.ready      = (state_q == FR_IDLE);
    wr_o.valid         = push;
    wr_o.op.kind       = OP_BYTE;
    wr_o.op.rs         = 1'b0;
    wr_o.op.value      = byte_q;
    wr_o.op.clear_extra = 1'b0;
    wr_o.op.last       = last_push;
    case (cmd_q)
      CMD_DATA: begin
        wr_o.op.rs = 1'b1;
      end
      CMD_INIT: begin
        if (step_q == 3'd0) begin
          wr_o.op.kind = OP_WAKE;
        end
        wr_o.op.value       = init_byte;
        wr_o.op.clear_extra = (step_q == INIT_LAST_STEP);
      end
      CMD_PRINT: begin
        wr_o.op.rs    = 1'b1;
        wr_o.op.value = digit_char;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (push) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_ch_i.payload.cmd);
      byte_q <= (in_ch_i.payload.cmd == CMD_CURSOR) ? cursor_byte
                                                    : in_ch_i.payload.byte_value;
      rem_q  <= in_ch_i.payload.number;
    end else if (push) begin
      rem_q  <= rem_next;
    end
  end

endmodule

>>> sv/lcd4_fifo.sv
module lcd4_fifo #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcd4_pkg::q_xfer_t wr_i,
  output logic              full_o,
  output lcd4_pkg::q_xfer_t rd_o,
  input  logic              pop_i
);
  import lcd4_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;

  assign full_o   = (count_q == CntW'(Depth));
  assign do_push  = wr_i.valid && !full_o;
  assign rd_o.valid = (count_q != '0);
  assign rd_o.op  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.op;
    end
  end

endmodule

>>> sv/lcd4_back.sv
module lcd4_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcd4_pkg::timing_t timing_i,
  input  lcd4_pkg::q_xfer_t rd_i,
  output logic              pop_o,
  lcd4_chan_if.source       out_ch_o
);
  import lcd4_pkg::*;

  back_state_e state_q, state_d;
  op_t         cur_q;
  logic [3:0]  phase_q;
  pin_t        out_q;
  logic        out_valid_q;

  logic        emit;
  logic        final_phase;
  logic        load;
  logic [16:0] settle_sum;
  logic [15:0] settle_hold;
  logic [3:0]  hi_nib;
  logic [3:0]  lo_nib;
  pin_t        pin_d;

  assign final_phase = (cur_q.kind == OP_WAKE) ? (phase_q == WAKE_LAST_PHASE)
                                               : (phase_q == BYTE_LAST_PHASE);
  assign emit  = (state_q == BK_RUN) && (!out_valid_q || out_ch_o.ready);
  assign load  = ((state_q == BK_IDLE) || (emit && final_phase)) && rd_i.valid;
  assign pop_o = load;

  assign settle_sum  = {1'b0, timing_i.byte_settle_us} + {1'b0, CLEAR_EXTRA_US};
  assign settle_hold = !cur_q.clear_extra ? timing_i.byte_settle_us
                     : (settle_sum[16] ? 16'hFFFF : settle_sum[15:0]);
  assign hi_nib = cur_q.value[7:4];
  assign lo_nib = cur_q.value[3:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (rd_i.valid) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && final_phase && !rd_i.valid) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Pin levels for the current phase.
  always_comb begin
    pin_d.reg_select  = cur_q.rs;
    pin_d.read_write  = 1'b0;
    pin_d.enable      = 1'b0;
    pin_d.data_nibble = lo_nib;
    pin_d.hold_us     = '0;
    pin_d.last        = 1'b0;
    if (cur_q.kind == OP_WAKE) begin
      case (phase_q)
        4'd0: begin
          pin_d.data_nibble = 4'h0;
          pin_d.hold_us     = POWER_UP_US;
        end
        4'd1, 4'd3, 4'd5: begin
          pin_d.enable      = 1'b1;
          pin_d.data_nibble = WAKE_NIB;
          pin_d.hold_us     = timing_i.enable_pulse_us;
        end
        4'd2: begin
          pin_d.data_nibble = WAKE_NIB;
          pin_d.hold_us     = WAKE1_WAIT_US;
        end
        4'd4: begin
          pin_d.data_nibble = WAKE_NIB;
          pin_d.hold_us     = WAKE2_WAIT_US;
        end
        4'd6: begin
          pin_d.data_nibble = WAKE_NIB;
          pin_d.hold_us     = WAKE3_WAIT_US;
        end
        4'd7: begin
          pin_d.enable      = 1'b1;
          pin_d.data_nibble = FOUR_BIT_NIB;
          pin_d.hold_us     = timing_i.enable_pulse_us;
        end
        default: begin
          pin_d.data_nibble = FOUR_BIT_NIB;
          pin_d.hold_us     = WAKE4_WAIT_US;
        end
      endcase
    end else begin
      case (phase_q)
        4'd0: begin
          pin_d.data_nibble = hi_nib;
        end
        4'd1: begin
          pin_d.enable      = 1'b1;
          pin_d.data_nibble = hi_nib;
          pin_d.hold_us     = timing_i.enable_pulse_us;
        end
        4'd2: ;
        4'd3: begin
          pin_d.enable  = 1'b1;
          pin_d.hold_us = timing_i.enable_pulse_us;
        end
        default: begin
          pin_d.hold_us = settle_hold;
          pin_d.last    = cur_q.last;
        end
      endcase
    end
  end

  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        phase_q <= '0;
      end else if (emit) begin
        phase_q <= phase_q + 4'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= rd_i.op;
    end
    if (emit) begin
      out_q <= pin_d;
    end
  end

endmodule

>>> sv/lcd4_sva.sv
module lcd4_sva (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input lcd4_pkg::pin_t out_pin_i
);
  import lcd4_pkg::*;

  logic prev_en_q;
  logic out_fire;

  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_en_q <= 1'b0;
    end else if (out_fire) begin
      prev_en_q <= out_pin_i.enable;
    end
  end

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pin_i))
    else $error("stalled result changed");

  // Never read from the display.
  a_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_pin_i.read_write == 1'b0)
    else $error("RW driven high");

  // A run ends with E low.
  a_last_en_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pin_i.enable |-> !out_pin_i.last)
    else $error("run ends with E high");

  // Drop E after every strobe before the next one.
  a_no_double_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_en_q |-> !out_pin_i.enable)
    else $error("two E-high phases in a row");

endmodule

bind char_lcd_4bit_interface_sequencer_unit lcd4_sva u_lcd4_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_pin_i   (out_ch_o.payload)
);
